FILE: design/tsng_pkg.sv
// Shared types, register codes and constants for the tone generator.
// Also holds the sine series function that builds the quarter-wave ROM at elaboration.
// No dependencies.
package tsng_pkg;

  typedef enum logic [1:0] {
    MODE_SILENCE  = 2'd0,
    MODE_TRIANGLE = 2'd1,
    MODE_SINE     = 2'd2,
    MODE_NOISE    = 2'd3
  } mode_e;

  typedef enum logic {
    REG_MODE = 1'b0,
    REG_STEP = 1'b1
  } cfg_reg_e;

  // Control that travels with a word from the phase stage to the shaping stage
  typedef struct packed {
    logic use_rom;
    logic negate;
    logic last;
  } wave_ctl_t;

  localparam logic [15:0] NOISE_SEED = 16'hACE1;
  localparam logic [15:0] NOISE_TAPS = 16'hB400;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_DIV [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

  // sin(x) for x in Q2.30, rounded to Q1.15 and saturated at +1.0
  function automatic logic [15:0] sine_q15(input longint unsigned x);
    longint unsigned term;
    longint          sum;
    longint unsigned r;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 10; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'(TAYLOR_DIV[k-1]);
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (64'(sum) + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return 16'(r);
  endfunction

endpackage

FILE: design/tsng_phase.sv
// Phase stage: waveform state (triangle level, table walk, noise LFSR) and the
// registered word handed to the shaping stage. Uses tsng_pkg.
module tsng_phase #(
  parameter int TABLE_ENTRIES = 256,
  parameter int FRAC_BITS     = 16,
  localparam int IW = $clog2(TABLE_ENTRIES)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     advance_i,
  input  logic                     restart_i,
  input  tsng_pkg::mode_e          mode_i,
  input  logic [FRAC_BITS+1:0]     phase_step_i,
  input  logic                     last_i,
  output tsng_pkg::wave_ctl_t      ctl_o,
  output logic [15:0]              sample_o,
  output logic [IW-1:0]            idx_o
);

  localparam int SW   = FRAC_BITS + 2;
  localparam int TW   = FRAC_BITS + 3;
  localparam int PW   = IW + FRAC_BITS + 4;
  localparam int SH_R = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
  localparam int SH_L = (FRAC_BITS < 15) ? 15 - FRAC_BITS : 0;
  localparam int UW   = FRAC_BITS + 2 + SH_L;

  localparam logic [SW-1:0]        STEP_MAX  = SW'(2) << FRAC_BITS;
  localparam logic signed [TW-1:0] ONE_T     = TW'(1) << FRAC_BITS;
  localparam logic signed [TW-1:0] TWO_T     = TW'(2) << FRAC_BITS;
  localparam logic signed [PW-1:0] END_S     = PW'(TABLE_ENTRIES) << FRAC_BITS;
  localparam logic signed [PW-1:0] TWO_END_S = PW'(TABLE_ENTRIES) << (FRAC_BITS + 1);
  localparam logic signed [PW-1:0] LIM_S     = PW'(TABLE_ENTRIES) << (FRAC_BITS + 2);
  localparam logic signed [PW-1:0] LAST_S    = PW'(TABLE_ENTRIES - 1);
  localparam logic [IW-1:0]        LAST_IDX  = IW'(TABLE_ENTRIES - 1);

  logic signed [TW-1:0] tri_level_q, tri_level_d;
  logic                 tri_falling_q, tri_falling_d;
  logic signed [PW-1:0] table_pos_q, table_pos_d;
  logic                 table_backward_q, table_backward_d;
  logic                 negative_half_q, negative_half_d;
  logic [15:0]          noise_q, noise_d;

  tsng_pkg::wave_ctl_t  ctl_q, ctl_d;
  logic [15:0]          sample_q, sample_d;
  logic [IW-1:0]        idx_q, idx_d;

  logic [SW-1:0]        step_sat;
  logic signed [TW-1:0] tri_step, tri_sum;
  logic [UW-1:0]        tri_u;
  logic [16:0]          tri_q17;
  logic [15:0]          tri_sample;
  logic signed [PW-1:0] sine_step, pos_sum, pos_fold, pos_shift;

  always_comb begin
    step_sat = (phase_step_i > STEP_MAX) ? STEP_MAX : phase_step_i;

    // Triangle: add the step, fold back at +-1.0
    tri_step      = $signed(TW'(step_sat));
    tri_sum       = tri_falling_q ? tri_level_q - tri_step : tri_level_q + tri_step;
    tri_falling_d = tri_falling_q;
    if (tri_sum > ONE_T) begin
      tri_level_d   = TWO_T - tri_sum;
      tri_falling_d = !tri_falling_q;
    end else if (tri_sum < -ONE_T) begin
      tri_level_d   = -TWO_T - tri_sum;
      tri_falling_d = !tri_falling_q;
    end else begin
      tri_level_d   = tri_sum;
    end
    // Offset into 0..2.0, align to 15 fraction bits, then re-center
    tri_u      = UW'(tri_level_d + ONE_T) << SH_L;
    tri_q17    = 17'(tri_u >> SH_R);
    tri_sample = tri_q17[16] ? 16'h7FFF : {~tri_q17[15], tri_q17[14:0]};

    // Sine: walk the quarter table, reflect at the far end, flip sign at zero
    sine_step        = $signed(PW'(step_sat)) * $signed(PW'(TABLE_ENTRIES));
    pos_sum          = table_backward_q ? table_pos_q - sine_step : table_pos_q + sine_step;
    table_backward_d = table_backward_q;
    negative_half_d  = negative_half_q;
    if (pos_sum >= END_S) begin
      pos_fold         = TWO_END_S - pos_sum;
      table_backward_d = !table_backward_q;
    end else if (pos_sum < 0) begin
      pos_fold         = -pos_sum;
      table_backward_d = !table_backward_q;
      negative_half_d  = !negative_half_q;
    end else begin
      pos_fold         = pos_sum;
    end
    if (pos_fold > LIM_S) begin
      table_pos_d = LIM_S;
    end else if (pos_fold < -LIM_S) begin
      table_pos_d = -LIM_S;
    end else begin
      table_pos_d = pos_fold;
    end
    pos_shift = table_pos_d >>> FRAC_BITS;
    if (table_pos_d < 0) begin
      idx_d = '0;
    end else if (pos_shift > LAST_S) begin
      idx_d = LAST_IDX;
    end else begin
      idx_d = IW'(pos_shift);
    end

    // Noise: shift first, then read
    noise_d = {1'b0, noise_q[15:1]} ^ (noise_q[0] ? tsng_pkg::NOISE_TAPS : 16'h0000);

    ctl_d.use_rom = (mode_i == tsng_pkg::MODE_SINE);
    ctl_d.negate  = negative_half_d;
    ctl_d.last    = last_i;
    case (mode_i)
      tsng_pkg::MODE_TRIANGLE: sample_d = tri_sample;
      tsng_pkg::MODE_NOISE:    sample_d = noise_d;
      default:                 sample_d = 16'h0000;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_level_q      <= -ONE_T;
      tri_falling_q    <= 1'b0;
      table_pos_q      <= '0;
      table_backward_q <= 1'b0;
      negative_half_q  <= 1'b0;
      noise_q          <= tsng_pkg::NOISE_SEED;
    end else if (restart_i) begin
      tri_level_q      <= -ONE_T;
      tri_falling_q    <= 1'b0;
      table_pos_q      <= '0;
      table_backward_q <= 1'b0;
      negative_half_q  <= 1'b0;
    end else if (advance_i) begin
      // advance only the selected waveform
      case (mode_i)
        tsng_pkg::MODE_TRIANGLE: begin
          tri_level_q   <= tri_level_d;
          tri_falling_q <= tri_falling_d;
        end
        tsng_pkg::MODE_SINE: begin
          table_pos_q      <= table_pos_d;
          table_backward_q <= table_backward_d;
          negative_half_q  <= negative_half_d;
        end
        tsng_pkg::MODE_NOISE: begin
          noise_q <= noise_d;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      ctl_q    <= ctl_d;
      sample_q <= sample_d;
      idx_q    <= idx_d;
    end
  end

  assign ctl_o    = ctl_q;
  assign sample_o = sample_q;
  assign idx_o    = idx_q;

endmodule

FILE: design/tsng_shape.sv
// Shaping stage: quarter-wave sine ROM built at elaboration, sign flip and
// waveform select. Uses tsng_pkg for the series function and control struct.
module tsng_shape #(
  parameter int TABLE_ENTRIES = 256,
  localparam int IW = $clog2(TABLE_ENTRIES)
) (
  input  tsng_pkg::wave_ctl_t ctl_i,
  input  logic [15:0]         sample_i,
  input  logic [IW-1:0]       idx_i,
  output logic [15:0]         sample_o
);

  logic [15:0] rom_w [TABLE_ENTRIES];
  logic [15:0] rom_val;

  for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_rom
    localparam longint unsigned ARG_Q30 =
      (tsng_pkg::HALF_PI_Q30 * 64'(gi)) / TABLE_ENTRIES;
    assign rom_w[gi] = tsng_pkg::sine_q15(ARG_Q30);
  end

  always_comb begin
    rom_val = rom_w[idx_i];
    if (ctl_i.use_rom) begin
      sample_o = ctl_i.negate ? (~rom_val + 16'd1) : rom_val;
    end else begin
      sample_o = sample_i;
    end
  end

endmodule

FILE: design/triangle_sine_noise_tone_generator_core.sv
// Tone generator top level: configuration registers, two-stage pipeline
// control and output register. Uses tsng_pkg, tsng_phase and tsng_shape.
//
// Usage:
//   Config port: cfg_we_i writes cfg_wdata_i into the register at cfg_index_i
//   (mode, then phase_step) on the same edge. Any write restarts the triangle
//   and the sine; the noise LFSR keeps running from where it stood. Write only
//   while no word is in flight.
//   Input channel: one word per sample tick, carrying end_of_buffer_i.
//   Output channel: one stereo word per input word, the same sample on both
//   channels, last_o copied from end_of_buffer_i.
//   An input word passes through the phase stage register, then the output
//   register after the ROM read. Throughput is one word per cycle while the
//   receiver keeps up; the triangle, table walk and LFSR each close their
//   loop in the phase stage.
//   When the receiver stalls, the output register holds its word and the
//   phase stage holds one more; in_ready_o drops only when both are full.
//   Reset: mode is silence, phase_step is zero, the triangle sits at -1.0
//   rising, the table walk at entry zero in the positive half, and the LFSR
//   at its seed. The pipeline comes up empty.
module triangle_sine_noise_tone_generator_core #(
  parameter int TABLE_ENTRIES = 256,
  parameter int FRAC_BITS     = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [FRAC_BITS+1:0]     cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     end_of_buffer_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [15:0]       left_sample_o,
  output logic signed [15:0]       right_sample_o,
  output logic                     last_o
);

  localparam int IW = $clog2(TABLE_ENTRIES);

  tsng_pkg::mode_e      mode_q;
  logic [FRAC_BITS+1:0] step_q;

  logic                 in_accept;
  logic                 a_valid_q, a_valid_d;
  logic                 b_load;
  logic                 out_valid_q, out_valid_d;
  logic [15:0]          out_sample_q;
  logic                 out_last_q;

  tsng_pkg::wave_ctl_t  a_ctl;
  logic [15:0]          a_sample;
  logic [IW-1:0]        a_idx;
  logic [15:0]          b_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tsng_pkg::MODE_SILENCE;
      step_q <= '0;
    end else if (cfg_we_i) begin
      unique case (tsng_pkg::cfg_reg_e'(cfg_index_i))
        tsng_pkg::REG_MODE: mode_q <= tsng_pkg::mode_e'(cfg_wdata_i[1:0]);
        tsng_pkg::REG_STEP: step_q <= cfg_wdata_i;
      endcase
    end
  end

  // Advance a word into the output register whenever it is empty or draining
  always_comb begin
    b_load      = a_valid_q && (!out_valid_q || out_ready_i);
    in_ready_o  = !a_valid_q || b_load;
    in_accept   = in_valid_i && in_ready_o;
    a_valid_d   = in_accept || (a_valid_q && !b_load);
    out_valid_d = b_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  tsng_phase #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .FRAC_BITS    (FRAC_BITS)
  ) u_phase (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (in_accept),
    .restart_i    (cfg_we_i),
    .mode_i       (mode_q),
    .phase_step_i (step_q),
    .last_i       (end_of_buffer_i),
    .ctl_o        (a_ctl),
    .sample_o     (a_sample),
    .idx_o        (a_idx)
  );

  tsng_shape #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_shape (
    .ctl_i    (a_ctl),
    .sample_i (a_sample),
    .idx_i    (a_idx),
    .sample_o (b_sample)
  );

  always_ff @(posedge clk_i) begin
    if (b_load) begin
      out_sample_q <= b_sample;
      out_last_q   <= a_ctl.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = $signed(out_sample_q);
  assign right_sample_o = $signed(out_sample_q);
  assign last_o         = out_last_q;

  // An accepted word always lands in the phase stage
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> a_valid_q)
    else $error("accepted word did not enter the phase stage");

  // A word moved to the output register carries its own last flag
  a_last_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_load |=> (out_valid_q && out_last_q == $past(a_ctl.last)))
    else $error("output word lost or last flag mismatched");

  // The clamped table index never runs past the last entry
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && a_ctl.use_rom) |-> (32'(a_idx) < TABLE_ENTRIES))
    else $error("table index beyond last entry");

  // Silence produces a zero word and never touches the ROM
  a_silence_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && mode_q == tsng_pkg::MODE_SILENCE) |-> (a_sample == 16'h0000 && !a_ctl.use_rom))
    else $error("silence mode produced a nonzero word");

endmodule

FILE: tb/tb_triangle_sine_noise_tone_generator_core.sv
// Self-checking testbench for triangle_sine_noise_tone_generator_core.
// Drives sample ticks and register writes, predicts every output frame
// in-line and compares it. Depends on tsng_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_triangle_sine_noise_tone_generator_core;

  localparam int     TABLE_N     = 256;
  localparam int     FRAC        = 16;
  localparam longint ONE         = longint'(1) << FRAC;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     LONG_HOLD   = 300;

  typedef struct {
    logic signed [15:0] left_s;
    logic signed [15:0] right_s;
    logic               eob;
  } frame_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic               cfg_index_i     = 1'b0;
  logic [17:0]        cfg_wdata_i     = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic               end_of_buffer_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  logic signed [15:0] left_sample_o;
  logic signed [15:0] right_sample_o;
  logic               last_o;

  triangle_sine_noise_tone_generator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .end_of_buffer_i (end_of_buffer_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .left_sample_o   (left_sample_o),
    .right_sample_o  (right_sample_o),
    .last_o          (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Tone state mirrored from the block
  logic signed [15:0] sine_rom [TABLE_N];
  tsng_pkg::mode_e    cur_mode;
  logic [17:0]        cur_step;
  longint             tri_lvl;
  bit                 tri_down;
  longint             rom_pos;
  bit                 rom_back;
  bit                 sine_neg;
  logic [15:0]        lfsr;

  logic   ticks_to_send [$];
  frame_t frames_due [$];
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  logic   hold_req       = 1'b0;
  int     hold_left      = 0;
  int     mismatches     = 0;
  int     cycle_count    = 0;

  // Taylor series of sin on a Q2.30 angle, rounded to Q1.15
  function automatic logic signed [15:0] quarter_sine(input int unsigned i);
    longint unsigned ang;
    longint unsigned pw;
    longint unsigned rnd;
    longint          acc;
    ang = tsng_pkg::HALF_PI_Q30 * 64'(i) / 64'(TABLE_N);
    pw  = ang;
    acc = longint'(ang);
    for (int n = 1; n <= 10; n++) begin
      pw = (pw * ang) >> 30;
      pw = (pw * ang) >> 30;
      pw = pw / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(pw);
      else            acc = acc + longint'(pw);
    end
    if (acc < 0) acc = 0;
    rnd = (acc + 16384) >>> 15;
    if (rnd > 32767) rnd = 32767;
    return rnd[15:0];
  endfunction

  function automatic void rewind_waves();
    tri_lvl  = -ONE;
    tri_down = 1'b0;
    rom_pos  = 0;
    rom_back = 1'b0;
    sine_neg = 1'b0;
  endfunction

  // Advance the selected waveform by one tick and return its sample
  function automatic logic signed [15:0] next_tone_sample();
    longint stp;
    longint span;
    longint idx;
    longint v;
    logic   lsb;
    stp = longint'(cur_step);
    if (stp > 2 * ONE) stp = 2 * ONE;
    v = 0;
    case (cur_mode)
      tsng_pkg::MODE_TRIANGLE: begin
        tri_lvl = tri_down ? tri_lvl - stp : tri_lvl + stp;
        if (tri_lvl > ONE) begin
          tri_lvl  = 2 * ONE - tri_lvl;
          tri_down = !tri_down;
        end else if (tri_lvl < -ONE) begin
          tri_lvl  = -2 * ONE - tri_lvl;
          tri_down = !tri_down;
        end
        v = tri_lvl + ONE;
        if (v < 0) v = 0;
        if (v > 2 * ONE) v = 2 * ONE;
        v = (v >>> (FRAC - 15)) - 32768;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      tsng_pkg::MODE_SINE: begin
        stp  = stp * TABLE_N;
        span = longint'(TABLE_N) * ONE;
        rom_pos = rom_back ? rom_pos - stp : rom_pos + stp;
        if (rom_pos >= span) begin
          rom_pos  = 2 * span - rom_pos;
          rom_back = !rom_back;
        end else if (rom_pos < 0) begin
          rom_pos  = -rom_pos;
          rom_back = !rom_back;
          sine_neg = !sine_neg;
        end
        if (rom_pos > 4 * span) rom_pos = 4 * span;
        if (rom_pos < -4 * span) rom_pos = -4 * span;
        idx = (rom_pos < 0) ? 0 : (rom_pos >>> FRAC);
        if (idx > TABLE_N - 1) idx = TABLE_N - 1;
        v = sine_rom[idx];
        if (sine_neg) v = -v;
      end
      tsng_pkg::MODE_NOISE: begin
        lsb  = lfsr[0];
        lfsr = lfsr >> 1;
        if (lsb) lfsr = lfsr ^ tsng_pkg::NOISE_TAPS;
        v = longint'($signed(lfsr));
      end
      default: v = 0;
    endcase
    return v[15:0];
  endfunction

  // Sender: predict on accept, then offer the next pending word
  always @(posedge clk_i) begin
    logic signed [15:0] smp;
    frame_t             nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        smp         = next_tone_sample();
        nxt.left_s  = smp;
        nxt.right_s = smp;
        nxt.eob     = end_of_buffer_i;
        frames_due.push_back(nxt);
      end
      if (!in_valid_i || in_ready_o) begin
        if (ticks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i      <= 1'b1;
          end_of_buffer_i <= ticks_to_send.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req) hold_left <= LONG_HOLD;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // Receiver: check each accepted frame, then pick the next ready
  always @(posedge clk_i) begin
    frame_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (frames_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected frame left=%0d right=%0d last=%0d",
                                  left_sample_o, right_sample_o, last_o));
        end else begin
          want = frames_due.pop_front();
          if (left_sample_o !== want.left_s)
            flag_mismatch($sformatf("left_sample expected %0d, got %0d",
                                    want.left_s, left_sample_o));
          if (right_sample_o !== want.right_s)
            flag_mismatch($sformatf("right_sample expected %0d, got %0d",
                                    want.right_s, right_sample_o));
          if (last_o !== want.eob)
            flag_mismatch($sformatf("last expected %0d, got %0d", want.eob, last_o));
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("triangle_sine_noise_tone_generator_core test failed");
      $finish;
    end
  end

  task automatic write_reg(input tsng_pkg::cfg_reg_e idx, input logic [17:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    if (idx == tsng_pkg::REG_MODE) cur_mode = tsng_pkg::mode_e'(val[1:0]);
    else                           cur_step = val;
    rewind_waves();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_ticks(input int n);
    for (int k = 0; k < n; k++) ticks_to_send.push_back($urandom_range(7) == 0);
  endtask

  // Hold until every word has gone through, then let the pipeline settle
  task automatic drain();
    @(negedge clk_i);
    while (ticks_to_send.size() != 0 || in_valid_i || frames_due.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [17:0] pick_step();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return 18'($urandom_range(1, 1024));
      6, 7:             return 18'($urandom_range(0, 131072));
      8:                return 18'($urandom);
      default: begin
        case ($urandom_range(2))
          0:       return 18'd0;
          1:       return 18'd131072;
          default: return 18'h3FFFF;
        endcase
      end
    endcase
  endfunction

  initial begin
    for (int i = 0; i < TABLE_N; i++) sine_rom[i] = quarter_sine(i);
    cur_mode = tsng_pkg::MODE_SILENCE;
    cur_step = '0;
    lfsr     = tsng_pkg::NOISE_SEED;
    rewind_waves();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Silence after reset, both end markers
    ticks_to_send.push_back(1'b0);
    ticks_to_send.push_back(1'b1);
    drain();
    // Triangle: mode with upper data bits set, zero step parks at -1.0
    write_reg(tsng_pkg::REG_MODE, 18'h3FFFD);
    queue_ticks(2);
    drain();
    // Full-scale step reaches +1.0 and saturates
    write_reg(tsng_pkg::REG_STEP, 18'd131072);
    queue_ticks(3);
    drain();
    // Oversized step clamps to 2.0
    write_reg(tsng_pkg::REG_STEP, 18'h3FFFF);
    queue_ticks(2);
    drain();
    // Fold back inside the range
    write_reg(tsng_pkg::REG_STEP, 18'h0C000);
    queue_ticks(5);
    drain();
    // Sine: one table per tick hits the exact end and the sign flip
    write_reg(tsng_pkg::REG_MODE, 18'(tsng_pkg::MODE_SINE));
    write_reg(tsng_pkg::REG_STEP, 18'd65536);
    queue_ticks(4);
    drain();
    write_reg(tsng_pkg::REG_STEP, 18'd131072);
    queue_ticks(4);
    drain();
    write_reg(tsng_pkg::REG_MODE, 18'(tsng_pkg::MODE_NOISE));
    queue_ticks(4);
    drain();
    write_reg(tsng_pkg::REG_MODE, 18'h20000);
    queue_ticks(2);
    drain();

    // Receiver holds off long enough to back up the pipeline
    write_reg(tsng_pkg::REG_MODE, 18'(tsng_pkg::MODE_SINE));
    write_reg(tsng_pkg::REG_STEP, 18'd300);
    @(posedge clk_i);
    hold_req <= 1'b1;
    queue_ticks(40);
    @(posedge clk_i);
    hold_req <= 1'b0;
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      if ($urandom_range(1)) begin
        write_reg(tsng_pkg::REG_MODE, 18'($urandom));
        write_reg(tsng_pkg::REG_STEP, pick_step());
      end else begin
        write_reg(tsng_pkg::REG_STEP, pick_step());
        write_reg(tsng_pkg::REG_MODE, 18'($urandom));
      end
      queue_ticks($urandom_range(60, 100));
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("triangle_sine_noise_tone_generator_core test passed");
    end else begin
      $display("triangle_sine_noise_tone_generator_core test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/tsng_pkg.sv
design/tsng_phase.sv
design/tsng_shape.sv
design/triangle_sine_noise_tone_generator_core.sv
tb/tb_triangle_sine_noise_tone_generator_core.sv
